[hw/rtl/tdc_pkg.sv]
// Shared types, register codes and constants for the telescope drive controller.
package tdc_pkg;

   // Rate table depth and LED blink period while inhibited
   localparam int RATE_STEPS   = 32;
   localparam int BLINK_PERIOD = 500;

   // Button mask bit positions
   localparam int BTN_N    = 0;
   localparam int BTN_S    = 1;
   localparam int BTN_E    = 2;
   localparam int BTN_W    = 3;
   localparam int BTN_FIN  = 4;
   localparam int BTN_FOUT = 5;
   localparam int BTN_LAMP = 6;

   // AC pin bits
   localparam int AC_SQUARE = 0;
   localparam int AC_PHASE1 = 1;
   localparam int AC_PHASE2 = 2;

   // DC pin bits
   localparam int DC_FIN   = 0;
   localparam int DC_FOUT  = 1;
   localparam int DC_NORTH = 2;
   localparam int DC_SOUTH = 3;

   // Register reset values
   localparam logic [4:0]  RST_EAST_RATE      = 5'd0;
   localparam logic [4:0]  RST_SIDEREAL_RATE  = 5'd16;
   localparam logic [4:0]  RST_WEST_RATE      = 5'd31;
   localparam logic [15:0] RST_SPECIAL_RELOAD = 16'd0;
   localparam logic [9:0]  RST_STARTUP_TICKS  = 10'd1000;
   localparam logic [3:0]  RST_DEBOUNCE_LIMIT = 4'd10;
   localparam logic [9:0]  RST_ADC_LOW        = 10'd409;
   localparam logic [9:0]  RST_ADC_HIGH       = 10'd819;

   localparam int CSR_ADDR_W = 5;

   typedef enum logic [2:0] {
      REG_EAST_RATE,
      REG_SIDEREAL_RATE,
      REG_WEST_RATE,
      REG_SPECIAL_RELOAD,
      REG_STARTUP_TICKS,
      REG_DEBOUNCE_LIMIT,
      REG_ADC_LOW,
      REG_ADC_HIGH
   } csr_reg_type;

   typedef enum logic [1:0] {
      PHASE_RISE,
      PHASE_P1_END,
      PHASE_SWAP,
      PHASE_P2_END
   } seq_phase_type;

   typedef struct packed {
      logic        mode;
      logic        north_pressed;
      logic [9:0]  east_line;
      logic [9:0]  south_line;
      logic [9:0]  west_line;
      logic [6:0]  remote_buttons;
   } req_item_type;

   typedef struct packed {
      logic        phase_one;
      logic        phase_two;
      logic        square_wave;
      logic        focus_in_drive;
      logic        focus_out_drive;
      logic        north_drive;
      logic        south_drive;
      logic        lamp_lit;
      logic [6:0]  button_mask;
      logic [4:0]  rate_index;
      logic [15:0] reload_override;
      logic        inhibited;
   } rsp_item_type;

   typedef struct packed {
      logic [4:0]  east_rate_index;
      logic [4:0]  sidereal_rate_index;
      logic [4:0]  west_rate_index;
      logic [15:0] special_reload_count;
      logic [9:0]  startup_ticks;
      logic [3:0]  debounce_limit;
      logic [9:0]  adc_low_threshold;
      logic [9:0]  adc_high_threshold;
   } cfg_type;

   typedef struct packed {
      logic       inhibited;
      logic [4:0] rate;
   } status_type;

endpackage

[hw/rtl/tdc_csr.sv]
// APB-style configuration register file.
module tdc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [tdc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready,
   output tdc_pkg::cfg_type                   cfg
);
   import tdc_pkg::*;

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   csr_reg_type reg_sel;
   logic        wr_en;

   assign reg_sel    = csr_reg_type'(csr_paddr[4:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_EAST_RATE:      cfg_in.east_rate_index      = csr_pwdata[4:0];
            REG_SIDEREAL_RATE:  cfg_in.sidereal_rate_index  = csr_pwdata[4:0];
            REG_WEST_RATE:      cfg_in.west_rate_index      = csr_pwdata[4:0];
            REG_SPECIAL_RELOAD: cfg_in.special_reload_count = csr_pwdata[15:0];
            REG_STARTUP_TICKS:  cfg_in.startup_ticks        = csr_pwdata[9:0];
            REG_DEBOUNCE_LIMIT: cfg_in.debounce_limit       = csr_pwdata[3:0];
            REG_ADC_LOW:        cfg_in.adc_low_threshold    = csr_pwdata[9:0];
            REG_ADC_HIGH:       cfg_in.adc_high_threshold   = csr_pwdata[9:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_EAST_RATE:      csr_prdata = {27'd0, cfg_ff.east_rate_index};
         REG_SIDEREAL_RATE:  csr_prdata = {27'd0, cfg_ff.sidereal_rate_index};
         REG_WEST_RATE:      csr_prdata = {27'd0, cfg_ff.west_rate_index};
         REG_SPECIAL_RELOAD: csr_prdata = {16'd0, cfg_ff.special_reload_count};
         REG_STARTUP_TICKS:  csr_prdata = {22'd0, cfg_ff.startup_ticks};
         REG_DEBOUNCE_LIMIT: csr_prdata = {28'd0, cfg_ff.debounce_limit};
         REG_ADC_LOW:        csr_prdata = {22'd0, cfg_ff.adc_low_threshold};
         REG_ADC_HIGH:       csr_prdata = {22'd0, cfg_ff.adc_high_threshold};
         default:            csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.east_rate_index      <= RST_EAST_RATE;
         cfg_ff.sidereal_rate_index  <= RST_SIDEREAL_RATE;
         cfg_ff.west_rate_index      <= RST_WEST_RATE;
         cfg_ff.special_reload_count <= RST_SPECIAL_RELOAD;
         cfg_ff.startup_ticks        <= RST_STARTUP_TICKS;
         cfg_ff.debounce_limit       <= RST_DEBOUNCE_LIMIT;
         cfg_ff.adc_low_threshold    <= RST_ADC_LOW;
         cfg_ff.adc_high_threshold   <= RST_ADC_HIGH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[hw/rtl/tdc_core.sv]
// Event logic and controller state: AC sequencer, rate slew, button decode, LED.
module tdc_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  tdc_pkg::req_item_type  item,
   input  tdc_pkg::cfg_type       cfg,
   output tdc_pkg::rsp_item_type  result,
   output tdc_pkg::status_type    status
);
   import tdc_pkg::*;

   typedef enum logic [1:0] {
      LVL_OFF,
      LVL_MID,
      LVL_ON
   } adc_level_type;

   function automatic adc_level_type classify(input logic [9:0] v,
                                              input logic [9:0] lo,
                                              input logic [9:0] hi);
      adc_level_type lvl;
      if (v < lo)      lvl = LVL_OFF;
      else if (v > hi) lvl = LVL_ON;
      else             lvl = LVL_MID;
      return lvl;
   endfunction

   seq_phase_type phase_ff,   phase_in;
   logic [9:0]    startup_ff, startup_in;
   logic          inhibit_ff, inhibit_in;
   logic [4:0]    rate_ff,    rate_in;
   logic [4:0]    target_ff,  target_in;
   logic [3:0]    debounce_ff, debounce_in;
   logic [8:0]    blink_ff,   blink_in;
   logic          led_ff,     led_in;
   logic [6:0]    buttons_ff, buttons_in;
   logic [2:0]    ac_ff,      ac_in;
   logic [3:0]    dc_ff,      dc_in;

   logic [6:0]    btn;
   logic [6:0]    merged;
   logic [4:0]    want;
   logic [8:0]    blink_inc;
   adc_level_type lvl_east, lvl_south, lvl_west;

   assign lvl_east  = classify(item.east_line,  cfg.adc_low_threshold, cfg.adc_high_threshold);
   assign lvl_south = classify(item.south_line, cfg.adc_low_threshold, cfg.adc_high_threshold);
   assign lvl_west  = classify(item.west_line,  cfg.adc_low_threshold, cfg.adc_high_threshold);
   assign blink_inc = blink_ff + 9'd1;

   always_comb begin
      phase_in    = phase_ff;
      startup_in  = startup_ff;
      inhibit_in  = inhibit_ff;
      rate_in     = rate_ff;
      target_in   = target_ff;
      debounce_in = debounce_ff;
      blink_in    = blink_ff;
      led_in      = led_ff;
      buttons_in  = buttons_ff;
      ac_in       = ac_ff;
      dc_in       = dc_ff;
      btn         = 7'd0;
      merged      = 7'd0;
      want        = cfg.sidereal_rate_index;

      if (fire && item.mode) begin
         // timer event; release uses the updated inhibit flag
         if (startup_ff < cfg.startup_ticks) startup_in = startup_ff + 10'd1;
         else inhibit_in = 1'b0;
         unique case (phase_ff)
            PHASE_RISE: begin
               if (!inhibit_in) begin
                  ac_in[AC_SQUARE] = 1'b1;
                  ac_in[AC_PHASE1] = 1'b1;
               end
               phase_in = PHASE_P1_END;
            end
            PHASE_P1_END: begin
               if (!inhibit_in) ac_in[AC_PHASE1] = 1'b0;
               phase_in = PHASE_SWAP;
            end
            PHASE_SWAP: begin
               if (!inhibit_in) begin
                  ac_in[AC_SQUARE] = 1'b0;
                  ac_in[AC_PHASE2] = 1'b1;
               end
               phase_in = PHASE_P2_END;
            end
            PHASE_P2_END: begin
               if (!inhibit_in) ac_in[AC_PHASE2] = 1'b0;
               phase_in = PHASE_RISE;
               if (rate_ff < target_ff)      rate_in = rate_ff + 5'd1;
               else if (rate_ff > target_ff) rate_in = rate_ff - 5'd1;
            end
            default: phase_in = PHASE_RISE;
         endcase
      end else if (fire) begin
         // poll event
         if (item.north_pressed) begin
            if (debounce_ff >= cfg.debounce_limit) btn[BTN_N] = 1'b1;
            else debounce_in = debounce_ff + 4'd1;
         end else if (debounce_ff != 4'd0) begin
            debounce_in = debounce_ff - 4'd1;
         end
         if (lvl_east == LVL_OFF)       btn[BTN_E]    = 1'b1;
         else if (lvl_east == LVL_MID)  btn[BTN_LAMP] = 1'b1;
         if (lvl_south == LVL_OFF)      btn[BTN_S]    = 1'b1;
         else if (lvl_south == LVL_MID) btn[BTN_FIN]  = 1'b1;
         if (lvl_west == LVL_OFF)       btn[BTN_W]    = 1'b1;
         else if (lvl_west == LVL_MID)  btn[BTN_FOUT] = 1'b1;
         buttons_in = btn;
         merged     = btn | item.remote_buttons;

         if (!inhibit_ff) begin
            dc_in = 4'd0;
            if (merged[BTN_FIN])       dc_in[DC_FIN]  = 1'b1;
            else if (merged[BTN_FOUT]) dc_in[DC_FOUT] = 1'b1;
            if (merged[BTN_N])         dc_in[DC_NORTH] = 1'b1;
            else if (merged[BTN_S])    dc_in[DC_SOUTH] = 1'b1;
         end

         if (merged[BTN_E])      want = cfg.east_rate_index;
         else if (merged[BTN_W]) want = cfg.west_rate_index;
         if (want <= cfg.west_rate_index && {4'd0, want} < 9'(RATE_STEPS))
            target_in = want;

         if (inhibit_ff) begin
            if (blink_inc >= 9'(BLINK_PERIOD)) begin
               led_in   = !led_ff;
               blink_in = 9'd0;
            end else begin
               blink_in = blink_inc;
            end
         end else begin
            led_in = (merged != 7'd0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PHASE_RISE;
         startup_ff  <= 10'd0;
         inhibit_ff  <= 1'b1;
         rate_ff     <= RST_EAST_RATE;
         target_ff   <= RST_SIDEREAL_RATE;
         debounce_ff <= 4'd0;
         blink_ff    <= 9'd0;
         led_ff      <= 1'b0;
         buttons_ff  <= 7'd0;
         ac_ff       <= 3'd0;
         dc_ff       <= 4'd0;
      end else begin
         phase_ff    <= phase_in;
         startup_ff  <= startup_in;
         inhibit_ff  <= inhibit_in;
         rate_ff     <= rate_in;
         target_ff   <= target_in;
         debounce_ff <= debounce_in;
         blink_ff    <= blink_in;
         led_ff      <= led_in;
         buttons_ff  <= buttons_in;
         ac_ff       <= ac_in;
         dc_ff       <= dc_in;
      end
   end

   // result shows the state after the event
   always_comb begin
      result.phase_one       = ac_in[AC_PHASE1];
      result.phase_two       = ac_in[AC_PHASE2];
      result.square_wave     = ac_in[AC_SQUARE];
      result.focus_in_drive  = dc_in[DC_FIN];
      result.focus_out_drive = dc_in[DC_FOUT];
      result.north_drive     = dc_in[DC_NORTH];
      result.south_drive     = dc_in[DC_SOUTH];
      result.lamp_lit        = led_in;
      result.button_mask     = buttons_in;
      result.rate_index      = rate_in;
      result.reload_override = cfg.special_reload_count;
      result.inhibited       = inhibit_in;
   end

   assign status.inhibited = inhibit_ff;
   assign status.rate      = rate_ff;

endmodule

[hw/rtl/telescope_drive_controller.sv]
// Telescope drive controller top level: item pipeline, registers and core.
//
// Input channel (req_*): one item per event. mode 1 is an AC timer overflow,
// mode 0 a one-millisecond poll carrying the north switch, three handbox ADC
// samples and the host button mask. Result channel (rsp_*): exactly one item
// per input item, in order, holding pin levels, button mask, rate index,
// override reload count and the inhibit flag after that event.
// Items pass an input register and a result register with the event logic
// in between: a result is registered as its item leaves the input register;
// with rsp_stall low a new item is taken every cycle (one item per cycle sustained).
// When rsp_stall is high the result holds; one more item can sit in the
// input register, after which req_stall rises until the result is taken.
// Configuration (csr_*): APB-style, register i at byte address 4*i, written
// on the access cycle; pready is always high. Write only while idle.
// Reset (synchronous) restores register defaults, sets the startup inhibit,
// clears pins and counters, starts the rate at the east index reset value and
// the target at the sidereal reset value. No item is held across reset.
module telescope_drive_controller (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  tdc_pkg::req_item_type           req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output tdc_pkg::rsp_item_type           rsp_data,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tdc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import tdc_pkg::*;

   cfg_type      cfg;
   status_type   core_status;
   rsp_item_type core_result;

   logic         s1_valid_ff, s1_valid_in;
   req_item_type s1_item_ff,  s1_item_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff,  rsp_item_in;

   logic         out_ready;
   logic         advance;
   logic         req_fire;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_ready;
   assign req_stall = s1_valid_ff && !out_ready;
   assign req_fire  = req_valid && !req_stall;

   assign s1_valid_in  = req_fire || (s1_valid_ff && !advance);
   assign s1_item_in   = req_fire ? req_data : s1_item_ff;
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   assign rsp_item_in  = advance ? core_result : rsp_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff  <= s1_item_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_item_ff;

   tdc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tdc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (s1_item_ff),
      .cfg    (cfg),
      .result (core_result),
      .status (core_status)
   );

`ifndef SYNTHESIS
   // a blocked input item must stay put until the result register frees up
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_ready) |=> (s1_valid_ff && $stable(s1_item_ff)))
      else $error("held input item lost or changed");

   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed item produced no result");

   // startup inhibit only ever releases
   assert property (@(posedge clock) disable iff (reset)
      !$rose(core_status.inhibited))
      else $error("inhibit set again after release");

   assert property (@(posedge clock) disable iff (reset)
      (core_status.rate == $past(core_status.rate)) ||
      (core_status.rate == $past(core_status.rate) + 5'd1) ||
      (core_status.rate == $past(core_status.rate) - 5'd1))
      else $error("rate index moved by more than one step");
`endif

endmodule
